// ----- hw/rtl/kermit_data_field_encoder_macros.svh -----
`ifndef KERMIT_DATA_FIELD_ENCODER_MACROS_SVH
`define KERMIT_DATA_FIELD_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define KDFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define KDFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/kdfe_pkg.sv -----
`default_nettype none

package kdfe_pkg;

   localparam int GROUP_MAX = 5;

   localparam logic [6:0] RUN_LIMIT     = 7'd94;
   localparam logic [7:0] CTRL_Z        = 8'd26;
   localparam logic [6:0] EIGHT_BIT_OFF = 7'd78;
   localparam logic [7:0] TOCHAR_OFFSET = 8'd32;
   localparam logic [6:0] CTL_LIMIT     = 7'd32;
   localparam logic [6:0] DEL_CHAR      = 7'd127;
   localparam logic [7:0] CTL_FLIP      = 8'h40;
   localparam logic [12:0] PACKET_SLACK = 13'd10;

   localparam logic [2:0] CSR_PACKET_SIZE   = 3'd0;
   localparam logic [2:0] CSR_CONTROL_QUOTE = 3'd1;
   localparam logic [2:0] CSR_EIGHT_BIT     = 3'd2;
   localparam logic [2:0] CSR_REPEAT_PREFIX = 3'd3;
   localparam logic [2:0] CSR_REPEAT_ENABLE = 3'd4;
   localparam logic [2:0] CSR_CTRL_Z_END    = 3'd5;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       last_of_item;
   } rsp_type;

   typedef struct packed {
      logic [11:0] packet_size;
      logic [6:0]  control_quote;
      logic [6:0]  eight_bit_prefix;
      logic [6:0]  repeat_prefix;
      logic        repeat_enable;
      logic        ctrl_z_is_end;
   } cfg_type;

   // one encoded group, characters packed from slot 0
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] chars;
      logic [2:0]                count;
      logic                      pkt_end;
   } grp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/kdfe_front.sv -----
`default_nettype none
`include "kermit_data_field_encoder_macros.svh"

module kdfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kdfe_pkg::cfg_type cfg,
   input  wire logic             accept,
   input  wire kdfe_pkg::req_type req,
   output logic                  grp_push,
   output kdfe_pkg::grp_type     grp
);

   logic [7:0]  pending_byte_ff, pending_byte_in;
   logic        pending_valid_ff, pending_valid_in;
   logic [6:0]  run_count_ff, run_count_in;
   logic [11:0] field_length_ff, field_length_in;
   logic        file_ended_ff, file_ended_in;

   logic        is_end;
   logic        merge;
   logic        ebq_on;
   logic [7:0]  c;
   logic [2:0]  n;
   logic [12:0] sum;
   logic        close;

   assign ebq_on = cfg.eight_bit_prefix != kdfe_pkg::EIGHT_BIT_OFF;
   assign is_end = (req.cmd == kdfe_pkg::CMD_EOF) ||
                   (cfg.ctrl_z_is_end && req.data_byte == kdfe_pkg::CTRL_Z);
   assign merge  = pending_valid_ff && cfg.repeat_enable &&
                   req.data_byte == pending_byte_ff && run_count_ff < kdfe_pkg::RUN_LIMIT;

   // build the group for the pending byte
   always_comb begin
      n = 3'd0;
      grp = '0;
      c = pending_byte_ff;
      if (run_count_ff > 7'd1) begin
         grp.chars[n] = {1'b0, cfg.repeat_prefix};
         n = n + 3'd1;
         grp.chars[n] = {1'b0, run_count_ff} + kdfe_pkg::TOCHAR_OFFSET;
         n = n + 3'd1;
      end
      if (ebq_on && c[7]) begin
         grp.chars[n] = {1'b0, cfg.eight_bit_prefix};
         n = n + 3'd1;
         c[7] = 1'b0;
      end
      if (c[6:0] < kdfe_pkg::CTL_LIMIT || c[6:0] == kdfe_pkg::DEL_CHAR) begin
         grp.chars[n] = {1'b0, cfg.control_quote};
         n = n + 3'd1;
         c = c ^ kdfe_pkg::CTL_FLIP;
      end else if (c[6:0] == cfg.control_quote ||
                   (ebq_on && c[6:0] == cfg.eight_bit_prefix) ||
                   (cfg.repeat_enable && c[6:0] == cfg.repeat_prefix)) begin
         grp.chars[n] = {1'b0, cfg.control_quote};
         n = n + 3'd1;
      end
      grp.chars[n] = c;
      n = n + 3'd1;
      grp.count = n;
      sum = {1'b0, field_length_ff} + {10'd0, n};
      close = is_end || (sum + kdfe_pkg::PACKET_SLACK >= {1'b0, cfg.packet_size});
      grp.pkt_end = close;
   end

   assign grp_push = accept && !file_ended_ff && pending_valid_ff && (is_end || !merge);

   always_comb begin
      pending_byte_in  = pending_byte_ff;
      pending_valid_in = pending_valid_ff;
      run_count_in     = run_count_ff;
      field_length_in  = field_length_ff;
      file_ended_in    = file_ended_ff;
      if (grp_push) begin
         field_length_in = close ? 12'd0 : sum[11:0];
      end
      if (accept && !file_ended_ff) begin
         if (is_end) begin
            file_ended_in    = 1'b1;
            pending_valid_in = 1'b0;
            run_count_in     = 7'd1;
         end else if (merge) begin
            run_count_in = run_count_ff + 7'd1;
         end else begin
            pending_byte_in  = req.data_byte;
            pending_valid_in = 1'b1;
            run_count_in     = 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_byte_ff  <= 8'd0;
         pending_valid_ff <= 1'b0;
         run_count_ff     <= 7'd1;
         field_length_ff  <= 12'd0;
         file_ended_ff    <= 1'b0;
      end else begin
         pending_byte_ff  <= pending_byte_in;
         pending_valid_ff <= pending_valid_in;
         run_count_ff     <= run_count_in;
         field_length_ff  <= field_length_in;
         file_ended_ff    <= file_ended_in;
      end
   end

   `KDFE_ASSERT_NOW(a_no_group_after_end, clock, reset, file_ended_ff, !grp_push, "group after end of file")
   `KDFE_ASSERT_NOW(a_run_in_range, clock, reset, 1'b1, run_count_ff >= 7'd1 && run_count_ff <= kdfe_pkg::RUN_LIMIT, "run count out of range")

endmodule

`default_nettype wire

// ----- hw/rtl/kdfe_group_queue.sv -----
`default_nettype none
`include "kermit_data_field_encoder_macros.svh"

module kdfe_group_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire kdfe_pkg::grp_type push_grp,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output kdfe_pkg::grp_type     head_grp
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   kdfe_pkg::grp_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_grp   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_grp;
      end
   end

   `KDFE_ASSERT_NOW(a_push_not_full, clock, reset, push, !full, "group pushed into full queue")
   `KDFE_ASSERT_NOW(a_group_size, clock, reset, push, push_grp.count >= 3'd1 && push_grp.count <= 3'(kdfe_pkg::GROUP_MAX), "group size out of range")
   `KDFE_ASSERT_NEXT(a_count_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CW'(1), "queue count did not rise")

endmodule

`default_nettype wire

// ----- hw/rtl/kdfe_back.sv -----
`default_nettype none
`include "kermit_data_field_encoder_macros.svh"

module kdfe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire kdfe_pkg::grp_type head_grp,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output kdfe_pkg::rsp_type     rsp_data
);

   logic              out_valid_ff, out_valid_in;
   kdfe_pkg::rsp_type out_ff, out_in;
   logic [2:0]        idx_ff, idx_in;
   logic              load;
   logic              at_last;

   assign load      = !out_valid_ff || rsp_pop;
   assign at_last   = idx_ff == head_grp.count - 3'd1;
   assign head_pop  = load && head_valid && at_last;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = head_valid;
         if (head_valid) begin
            out_in.out_byte     = head_grp.chars[idx_ff];
            out_in.packet_end   = head_grp.pkt_end && at_last;
            out_in.last_of_item = at_last;
            idx_in              = at_last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
      out_ff <= out_in;
   end

   `KDFE_ASSERT_NOW(a_idx_in_group, clock, reset, head_valid, idx_ff < head_grp.count, "character index past group end")
   `KDFE_ASSERT_NOW(a_idx_idle, clock, reset, !head_valid, idx_ff == 3'd0, "index left mid-group with queue empty")

endmodule

`default_nettype wire

// ----- hw/rtl/kermit_data_field_encoder.sv -----
// channel   ports                           transfer when
// --------  ------------------------------  -------------------
// input     push full req_data              push && !full
// result    empty pop rsp_data              pop && !empty
// config    csr_write_enable csr_index      csr_write_enable
//           csr_data
//
// one input byte a cycle while full is low; each group of one to five characters is built
// combinationally by the front and drained one character a cycle by the back while popped
// full rises only when the group queue (QUEUE_DEPTH entries) is full
// a group's first result passes through the group queue, then the output register
// synchronous reset clears state and loads the register defaults; no clearing pass
`default_nettype none

module kermit_data_field_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire kdfe_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output kdfe_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [11:0]       csr_data
);

   kdfe_pkg::cfg_type cfg_ff, cfg_in;
   kdfe_pkg::grp_type grp, head_grp;
   logic              grp_push, head_valid, head_pop, accept;

   assign accept = push && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            kdfe_pkg::CSR_PACKET_SIZE:   cfg_in.packet_size      = csr_data;
            kdfe_pkg::CSR_CONTROL_QUOTE: cfg_in.control_quote    = csr_data[6:0];
            kdfe_pkg::CSR_EIGHT_BIT:     cfg_in.eight_bit_prefix = csr_data[6:0];
            kdfe_pkg::CSR_REPEAT_PREFIX: cfg_in.repeat_prefix    = csr_data[6:0];
            kdfe_pkg::CSR_REPEAT_ENABLE: cfg_in.repeat_enable    = csr_data[0];
            kdfe_pkg::CSR_CTRL_Z_END:    cfg_in.ctrl_z_is_end    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_size      <= 12'd94;
         cfg_ff.control_quote    <= 7'd35;
         cfg_ff.eight_bit_prefix <= 7'd78;
         cfg_ff.repeat_prefix    <= 7'd126;
         cfg_ff.repeat_enable    <= 1'b0;
         cfg_ff.ctrl_z_is_end    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kdfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .req      (req_data),
      .grp_push (grp_push),
      .grp      (grp)
   );

   kdfe_group_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_push),
      .push_grp   (grp),
      .full       (full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_grp   (head_grp)
   );

   kdfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_grp   (head_grp),
      .head_pop   (head_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- test/kermit_data_field_encoder_tb.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int HALF_PERIOD = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_LIMIT = 5000;
   localparam int RUN_TIMEOUT_NS = 10_000_000;
   localparam int REPORT_LIMIT = 100;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 17;
   localparam int PRESSURE_ITEMS = 40;
   localparam logic [2:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [2:0] CSR_UNMAPPED_HI = 3'd7;
   localparam logic [6:0] PRINT_LO = 7'd33;
   localparam logic [6:0] PRINT_HI = 7'd126;
   localparam kdfe_pkg::cfg_type RESET_CONFIG = '{
      packet_size: 12'd94, control_quote: 7'd35, eight_bit_prefix: kdfe_pkg::EIGHT_BIT_OFF,
      repeat_prefix: 7'd126, repeat_enable: 1'b0, ctrl_z_is_end: 1'b0};

   typedef enum {DRAIN_STEADY, DRAIN_HALF, DRAIN_SPARSE} drain_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   kdfe_pkg::req_type req_data = '0;
   logic              empty;
   logic              pop = 1'b0;
   kdfe_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [11:0]       csr_data = '0;

   // encoder state as the block should hold it
   kdfe_pkg::cfg_type csr_shadow = RESET_CONFIG;
   logic [7:0]        pend_byte = '0;
   bit                pend_valid = 1'b0;
   logic [6:0]        run_len = 7'd1;
   int                field_len = 0;
   bit                file_done = 1'b0;
   kdfe_pkg::rsp_type expected_chars [$];

   int             mismatches = 0;
   int             burst_left = 0;
   bit             sender_gaps = 1'b1;
   logic [7:0]     last_byte = '0;
   bit             hold_request = 1'b0;
   int             hold_left = 0;
   drain_kind_type drain_mode = DRAIN_STEADY;
   int             drain_left = 0;

   kermit_data_field_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data         (req_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < REPORT_LIMIT) begin
         $display("%0t ns: %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   // builds one group from the pending byte and queues its characters
   function automatic void encode_group(input bit force_end);
      logic [7:0]        grp [$];
      logic [7:0]        c;
      logic [6:0]        c7;
      bit                ebq_on;
      bit                closes;
      int                limit;
      kdfe_pkg::rsp_type r;
      c = pend_byte;
      ebq_on = (csr_shadow.eight_bit_prefix != kdfe_pkg::EIGHT_BIT_OFF);
      if (run_len > 1) begin
         grp.push_back({1'b0, csr_shadow.repeat_prefix});
         grp.push_back({1'b0, run_len} + kdfe_pkg::TOCHAR_OFFSET);
      end
      if (ebq_on && c[7]) begin
         grp.push_back({1'b0, csr_shadow.eight_bit_prefix});
         c[7] = 1'b0;
      end
      c7 = c[6:0];
      if (c7 < kdfe_pkg::CTL_LIMIT || c7 == kdfe_pkg::DEL_CHAR) begin
         grp.push_back({1'b0, csr_shadow.control_quote});
         c = c ^ kdfe_pkg::CTL_FLIP;
      end else if (c7 == csr_shadow.control_quote ||
                   (ebq_on && c7 == csr_shadow.eight_bit_prefix) ||
                   (csr_shadow.repeat_enable && c7 == csr_shadow.repeat_prefix)) begin
         grp.push_back({1'b0, csr_shadow.control_quote});
      end
      grp.push_back(c);
      field_len += grp.size();
      limit = int'(csr_shadow.packet_size) - int'(kdfe_pkg::PACKET_SLACK);
      closes = force_end || (field_len >= limit);
      if (closes) field_len = 0;
      foreach (grp[i]) begin
         r.out_byte = grp[i];
         r.packet_end = closes && (i == grp.size() - 1);
         r.last_of_item = (i == grp.size() - 1);
         expected_chars.push_back(r);
      end
      pend_valid = 1'b0;
      run_len = 7'd1;
   endfunction

   function automatic void encode_item(input kdfe_pkg::req_type item);
      if (file_done) return;
      if (item.cmd == kdfe_pkg::CMD_EOF ||
          (csr_shadow.ctrl_z_is_end && item.data_byte == kdfe_pkg::CTRL_Z)) begin
         if (pend_valid) encode_group(1'b1);
         file_done = 1'b1;
      end else if (pend_valid && csr_shadow.repeat_enable && item.data_byte == pend_byte &&
                   run_len < kdfe_pkg::RUN_LIMIT) begin
         run_len = run_len + 7'd1;
      end else begin
         if (pend_valid) encode_group(1'b0);
         pend_byte = item.data_byte;
         pend_valid = 1'b1;
         run_len = 7'd1;
      end
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [11:0] val);
      case (idx)
         kdfe_pkg::CSR_PACKET_SIZE:   csr_shadow.packet_size = val;
         kdfe_pkg::CSR_CONTROL_QUOTE: csr_shadow.control_quote = val[6:0];
         kdfe_pkg::CSR_EIGHT_BIT:     csr_shadow.eight_bit_prefix = val[6:0];
         kdfe_pkg::CSR_REPEAT_PREFIX: csr_shadow.repeat_prefix = val[6:0];
         kdfe_pkg::CSR_REPEAT_ENABLE: csr_shadow.repeat_enable = val[0];
         kdfe_pkg::CSR_CTRL_Z_END:    csr_shadow.ctrl_z_is_end = val[0];
         default: ;
      endcase
   endfunction

   task automatic check_char(input kdfe_pkg::rsp_type got);
      kdfe_pkg::rsp_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch("out_byte with nothing expected", int'(got.out_byte), 0);
      end else begin
         want = expected_chars.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
         if (got.packet_end !== want.packet_end)
            report_mismatch("packet_end", int'(got.packet_end), int'(want.packet_end));
         if (got.last_of_item !== want.last_of_item)
            report_mismatch("last_of_item", int'(got.last_of_item), int'(want.last_of_item));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty) check_char(rsp_data);
   end

   // receiver: changing pop patterns, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         if (drain_left == 0) begin
            drain_mode = drain_kind_type'($urandom_range(0, 2));
            drain_left = $urandom_range(5, 60);
         end
         drain_left--;
         case (drain_mode)
            DRAIN_STEADY: pop <= 1'b1;
            DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
            default:      pop <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // push stays high across a burst; a gap only opens between bursts
   task automatic send_item(input logic cmd, input logic [7:0] b);
      kdfe_pkg::req_type item;
      item.cmd = cmd;
      item.data_byte = b;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (sender_gaps && push) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
      end
      burst_left--;
      req_data <= item;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      encode_item(item);
      last_byte = b;
      @(negedge clock);
   endtask

   task automatic settle();
      push <= 1'b0;
      burst_left = 0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [11:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      apply_csr(idx, val);
      @(negedge clock);
   endtask

   // unused upper data bits carry noise
   task automatic load_config(input kdfe_pkg::cfg_type c);
      logic [31:0] noise_a;
      logic [31:0] noise_b;
      noise_a = $urandom;
      noise_b = $urandom;
      write_csr(kdfe_pkg::CSR_PACKET_SIZE, c.packet_size);
      write_csr(kdfe_pkg::CSR_CONTROL_QUOTE, {noise_a[4:0], c.control_quote});
      write_csr(kdfe_pkg::CSR_EIGHT_BIT, {noise_a[9:5], c.eight_bit_prefix});
      write_csr(kdfe_pkg::CSR_REPEAT_PREFIX, {noise_a[14:10], c.repeat_prefix});
      write_csr(kdfe_pkg::CSR_REPEAT_ENABLE, {noise_a[25:15], c.repeat_enable});
      write_csr(kdfe_pkg::CSR_CTRL_Z_END, {noise_b[10:0], c.ctrl_z_is_end});
      write_csr(noise_b[31] ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO, noise_b[22:11]);
      csr_write_enable <= 1'b0;
   endtask

   function automatic kdfe_pkg::cfg_type make_config(input logic [11:0] size,
                                                     input logic [6:0] cq,
                                                     input logic [6:0] ebq,
                                                     input logic [6:0] rpt,
                                                     input logic ren, input logic cz);
      kdfe_pkg::cfg_type c;
      c.packet_size = size;
      c.control_quote = cq;
      c.eight_bit_prefix = ebq;
      c.repeat_prefix = rpt;
      c.repeat_enable = ren;
      c.ctrl_z_is_end = cz;
      return c;
   endfunction

   function automatic logic [6:0] random_printable();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return PRINT_LO;
      if (sel == 1) return PRINT_HI;
      return 7'($urandom_range(PRINT_LO, PRINT_HI));
   endfunction

   function automatic kdfe_pkg::cfg_type random_config();
      kdfe_pkg::cfg_type c;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) c.packet_size = 12'($urandom_range(20, 40));
      else if (sel < 75) c.packet_size = 12'd4095;
      else if (sel < 85) c.packet_size = 12'd20;
      else c.packet_size = 12'($urandom_range(41, 200));
      c.control_quote = random_printable();
      c.eight_bit_prefix = ($urandom_range(0, 2) == 0) ? kdfe_pkg::EIGHT_BIT_OFF :
                                                         random_printable();
      c.repeat_prefix = random_printable();
      c.repeat_enable = 1'($urandom_range(0, 1));
      c.ctrl_z_is_end = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // file content biased towards runs, control bytes and prefix characters
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         b = last_byte;
      end else if (sel < 50) begin
         b = 8'($urandom_range(0, 31));
         if ($urandom_range(0, 7) == 0) b = {1'b0, kdfe_pkg::DEL_CHAR};
         b[7] = 1'($urandom_range(0, 1));
      end else if (sel < 70) begin
         case ($urandom_range(0, 2))
            0:       b = {1'b0, csr_shadow.control_quote};
            1:       b = {1'b0, csr_shadow.eight_bit_prefix};
            default: b = {1'b0, csr_shadow.repeat_prefix};
         endcase
         b[7] = 1'($urandom_range(0, 1));
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      // keep the file open until the last test
      if (csr_shadow.ctrl_z_is_end && b == kdfe_pkg::CTRL_Z) b = b ^ 8'h01;
      return b;
   endfunction

   task automatic test_basic_quoting();
      logic [7:0] seq [8] = '{8'h00, 8'hFF, 8'h7F, 8'h23, 8'h4E, 8'h80, 8'h1A, 8'h7E};
      foreach (seq[i]) send_item(kdfe_pkg::CMD_DATA, seq[i]);
   endtask

   // a byte with bit 7 set whose low seven bits equal the eight-bit prefix gets both the eight-bit and control quote
   task automatic test_prefix_quoting();
      logic [7:0] seq [7] = '{8'hC0, 8'hC0, 8'hC0, 8'hFE, 8'h80, 8'h21, 8'h7E};
      settle();
      load_config(make_config(12'd20, 7'd33, 7'd64, 7'd126, 1'b1, 1'b0));
      foreach (seq[i]) send_item(kdfe_pkg::CMD_DATA, seq[i]);
   endtask

   task automatic test_repeat_switched_off();
      repeat (4) send_item(kdfe_pkg::CMD_DATA, 8'h78);
      settle();
      load_config(make_config(12'd20, 7'd33, 7'd64, 7'd126, 1'b0, 1'b0));
      repeat (2) send_item(kdfe_pkg::CMD_DATA, 8'h78);
   endtask

   task automatic test_small_packets();
      settle();
      load_config(make_config(12'd10, 7'd35, kdfe_pkg::EIGHT_BIT_OFF, 7'd126, 1'b0, 1'b0));
      send_item(kdfe_pkg::CMD_DATA, 8'h41);
      send_item(kdfe_pkg::CMD_DATA, 8'hC2);
      send_item(kdfe_pkg::CMD_DATA, 8'h03);
      settle();
      load_config(make_config(12'd0, 7'd35, 7'd38, 7'd126, 1'b0, 1'b0));
      send_item(kdfe_pkg::CMD_DATA, 8'h44);
      send_item(kdfe_pkg::CMD_DATA, 8'h45);
   endtask

   task automatic test_run_limit();
      int lengths [2] = '{94, 95};
      logic [7:0] b;
      settle();
      load_config(make_config(12'd4095, 7'd35, kdfe_pkg::EIGHT_BIT_OFF, 7'd126, 1'b1, 1'b0));
      foreach (lengths[k]) begin
         b = 8'($urandom);
         if (b == last_byte) b = ~b;
         repeat (lengths[k]) send_item(kdfe_pkg::CMD_DATA, b);
         send_item(kdfe_pkg::CMD_DATA, ~b);
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         load_config(random_config());
         sender_gaps = (p != 3);
         repeat (PHASE_ITEMS) send_item(kdfe_pkg::CMD_DATA, pick_byte());
      end
      sender_gaps = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering, so full must rise
   task automatic test_pressure();
      settle();
      load_config(make_config(12'd20, 7'd35, 7'd38, 7'd126, 1'b0, 1'b0));
      hold_request = 1'b1;
      sender_gaps = 1'b0;
      repeat (PRESSURE_ITEMS) send_item(kdfe_pkg::CMD_DATA, pick_byte());
      sender_gaps = 1'b1;
   endtask

   task automatic test_end_of_file();
      settle();
      load_config(make_config(12'd94, 7'd35, kdfe_pkg::EIGHT_BIT_OFF, 7'd126, 1'b1, 1'b1));
      repeat (3) send_item(kdfe_pkg::CMD_DATA, 8'h41);
      send_item(kdfe_pkg::CMD_DATA, kdfe_pkg::CTRL_Z);
      // once the file has ended nothing more comes out
      send_item(kdfe_pkg::CMD_EOF, 8'hFF);
      send_item(kdfe_pkg::CMD_DATA, 8'h42);
      send_item(kdfe_pkg::CMD_DATA, 8'h42);
      send_item(kdfe_pkg::CMD_EOF, 8'h00);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_quoting();
      test_prefix_quoting();
      test_repeat_switched_off();
      test_small_packets();
      test_run_limit();
      test_random_phases();
      test_pressure();
      test_end_of_file();
      push <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && expected_chars.size() != 0; w++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_chars.size() != 0)
         report_mismatch("results never delivered", 0, expected_chars.size());
      if (mismatches == 0) begin
         $display("** kermit_data_field_encoder: PASSED **");
      end else begin
         $display("** kermit_data_field_encoder: FAILED **");
      end
      $finish;
   end

   initial begin
      #(RUN_TIMEOUT_NS);
      $display("** kermit_data_field_encoder: FAILED **");
      $finish;
   end

endmodule
